@@ rtl/sts_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Speed trip statistics package
// Shared widths, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
package sts_pkg;

  localparam int SPEED_W   = 16;
  localparam int COUNT_W   = 32;
  localparam int DIST_W    = 48;
  localparam int ADD_W     = 2 * SPEED_W;
  localparam int ACC_W     = SPEED_W + COUNT_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RESET      = 16'd256;
  localparam logic [SPEED_W-1:0] DISTANCE_SCALE_RESET = 16'd720;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_DONE
  } sts_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic div_start;
    logic commit;
  } sts_cmd_t;

  typedef struct packed {
    logic take;
    logic first;
    logic div_done;
    logic out_free;
  } sts_status_t;

endpackage

@@ rtl/sts_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Mean divider
// Restoring divider that yields a 16-bit quotient, one bit per cycle. The
// caller guarantees that the quotient fits, so the upper dividend bits start
// out as the partial remainder.
// ============================================================================
module sts_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sts_pkg::ACC_W-1:0]   dividend,
  input  logic [sts_pkg::COUNT_W-1:0] divisor,
  output logic                        done,
  output logic [sts_pkg::SPEED_W-1:0] quotient
);
  import sts_pkg::*;

  localparam int STEP_W = $clog2(SPEED_W);

  logic [COUNT_W-1:0] rem;
  logic [SPEED_W-1:0] low;
  logic [STEP_W-1:0]  step;
  logic               busy;

  logic [COUNT_W:0]   shifted;
  logic [COUNT_W+1:0] diff;
  logic               qbit;

  // The shifted remainder stays below twice the divisor, so one subtract
  // decides each quotient bit.
  always_comb begin
    shifted = {rem, low[SPEED_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    qbit    = ~diff[COUNT_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SPEED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[ACC_W-1:SPEED_W];
      low <= dividend[SPEED_W-1:0];
    end else if (busy) begin
      rem <= qbit ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      low <= {low[SPEED_W-2:0], qbit};
    end
  end

  assign quotient = low;

endmodule

@@ rtl/sts_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Speed trip statistics datapath
// Configuration registers, statistics state, multiplier stage, distance
// accumulator, mean divider and the result register.
// ============================================================================
module sts_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [sts_pkg::SPEED_W-1:0]    speed,
  input  logic                           out_stall,
  input  sts_pkg::sts_cmd_t              cmd,
  output sts_pkg::sts_status_t           sts,
  output logic                           out_valid,
  output logic                           accepted,
  output logic [sts_pkg::SPEED_W-1:0]    mean_speed,
  output logic [sts_pkg::SPEED_W-1:0]    peak_speed,
  output logic [sts_pkg::DIST_W-1:0]     distance_total,
  output logic [sts_pkg::COUNT_W-1:0]    sample_count
);
  import sts_pkg::*;

  logic [SPEED_W-1:0] min_speed;
  logic [SPEED_W-1:0] distance_scale;

  logic [COUNT_W-1:0] count_reg;
  logic [SPEED_W-1:0] mean_reg;
  logic [SPEED_W-1:0] peak_reg;
  logic [DIST_W-1:0]  distance_reg;
  logic               accepted_reg;

  logic [SPEED_W-1:0] speed_q;
  logic               take_q;
  logic [COUNT_W-1:0] n_reg;
  logic [ACC_W-1:0]   prod_reg;
  logic [ADD_W-1:0]   add_reg;
  logic [DIST_W-1:0]  dist_sum_reg;

  logic [COUNT_W-1:0] n_next;
  logic [COUNT_W-1:0] weight;
  logic [ACC_W-1:0]   acc;
  logic [DIST_W:0]    dist_sum;
  logic               div_done;
  logic [SPEED_W-1:0] quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed      <= MIN_SPEED_RESET;
      distance_scale <= DISTANCE_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SPEED:      min_speed      <= cfg_data;
        REG_DISTANCE_SCALE: distance_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Once the count saturates the divisor stays at its maximum and the
  // weight of the old mean is one less than that.
  always_comb begin
    n_next   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
    weight   = n_next - 1'b1;
    acc      = prod_reg + ACC_W'(speed_q);
    dist_sum = {1'b0, distance_reg} + (DIST_W + 1)'(add_reg);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      speed_q <= speed;
      take_q  <= (speed >= min_speed);
    end
    if (cmd.mul) begin
      n_reg    <= n_next;
      prod_reg <= mean_reg * weight;
      add_reg  <= speed_q * distance_scale;
    end
    if (cmd.add) begin
      dist_sum_reg <= dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
    end
  end

  sts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc),
    .divisor  (n_reg),
    .done     (div_done),
    .quotient (quotient)
  );

  // The state only moves when the result register is reloaded, so the
  // result fields read straight from the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg    <= '0;
      mean_reg     <= '0;
      peak_reg     <= '0;
      distance_reg <= '0;
      accepted_reg <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid    <= 1'b1;
        accepted_reg <= take_q;
        if (take_q) begin
          count_reg    <= n_reg;
          mean_reg     <= (count_reg == '0) ? speed_q : quotient;
          distance_reg <= dist_sum_reg;
          if (speed_q > peak_reg) begin
            peak_reg <= speed_q;
          end
        end
      end
    end
  end

  always_comb begin
    sts.take     = take_q;
    sts.first    = (count_reg == '0);
    sts.div_done = div_done;
    sts.out_free = !out_valid || !out_stall;
  end

  assign accepted       = accepted_reg;
  assign mean_speed     = mean_reg;
  assign peak_speed     = peak_reg;
  assign distance_total = distance_reg;
  assign sample_count   = count_reg;

endmodule

@@ rtl/sts_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Speed trip statistics controller
// Sequences one transaction through multiply, add, an optional divide and commit.
// ============================================================================
module sts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  sts_pkg::sts_status_t sts,
  output logic                 in_stall,
  output sts_pkg::sts_cmd_t    cmd
);
  import sts_pkg::*;

  sts_state_t state;
  sts_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = (sts.take && !sts.first) ? S_DIV : S_DONE;
      S_DIV:  if (sts.div_done) state_next = S_DONE;
      S_DONE: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.mul       = (state == S_MUL);
    cmd.add       = (state == S_ADD);
    cmd.div_start = (state == S_ADD) && sts.take && !sts.first;
    cmd.commit    = (state == S_DONE) && sts.out_free;
  end

endmodule

@@ rtl/speed_trip_statistics_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Speed trip statistics
// Running mean, peak speed, trip distance and sample count over Q8.8 speed
// samples, one result transaction for every input transaction.
// ============================================================================
// Each input transaction carries one Q8.8 speed sample. A sample at or above
// min_speed is counted: the saturating sample count rises, the mean becomes
// floor((mean*(n-1)+speed)/n) exactly, the peak speed follows the largest
// sample and speed*distance_scale is added to a 48-bit distance that
// saturates at its maximum. The first counted sample sets the mean directly.
// Every sample, counted or not, returns one result transaction with the
// accepted flag and the statistics as they stand after that sample. The block
// works on one sample at a time. A counted sample that updates an existing
// mean passes through the 16-step restoring divider, which produces the mean
// one quotient bit per cycle; a rejected sample or the first counted sample
// skips the divider. The next sample can be taken at the edge after the
// result has been placed in the output register, even while that result
// still waits on out_stall; a result can only be placed once the previous
// one has been taken. Configuration writes (index 0 min_speed, index 1
// distance_scale, others ignored) take effect at once and must only be
// made while no transaction is in flight.
module speed_trip_statistics_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sts_pkg::SPEED_W-1:0]    speed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           accepted,
  output logic [sts_pkg::SPEED_W-1:0]    mean_speed,
  output logic [sts_pkg::SPEED_W-1:0]    peak_speed,
  output logic [sts_pkg::DIST_W-1:0]     distance_total,
  output logic [sts_pkg::COUNT_W-1:0]    sample_count
);
  import sts_pkg::*;

  sts_cmd_t    cmd;
  sts_status_t sts;

  // The controller steps through the phases; the datapath holds all values.
  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sts_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .speed          (speed),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .accepted       (accepted),
    .mean_speed     (mean_speed),
    .peak_speed     (peak_speed),
    .distance_total (distance_total),
    .sample_count   (sample_count)
  );

  // An accepted transaction closes the input until its result is placed.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice without a commit in between");

  // A result is never placed over one that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // The sample count never goes down.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (sample_count >= $past(sample_count)))
    else $error("sample count decreased");

  // A mean of counted samples can never exceed the largest of them.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mean_speed <= peak_speed))
    else $error("mean speed above peak speed");

endmodule
